// ===== rtl/hfp_pkg.sv =====
// Shared types and constants of the HPACK field representation parser.
// No dependencies; every other file of the block imports this package.
package hfp_pkg;

  // Default width of the prefix integers (index and string lengths).
  localparam int unsigned IntBitsDef = 24;

  // Width of the table index as it leaves the block.
  localparam int unsigned IdxW = 24;

  // Prefix masks of the first byte and of a string length byte.
  localparam logic [7:0] PrefIndexed = 8'h7F;
  localparam logic [7:0] PrefIncr    = 8'h3F;
  localparam logic [7:0] PrefLiteral = 8'h0F;
  localparam logic [6:0] PrefLength  = 7'h7F;

  // Continuation bytes carry seven payload bits each.
  localparam int unsigned ContBits = 7;

  typedef enum logic [1:0] {
    KIND_INDEXED  = 2'd0,
    KIND_INCR     = 2'd1,
    KIND_NO_INDEX = 2'd2,
    KIND_NEVER    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PART_NONE  = 2'd0,
    PART_NAME  = 2'd1,
    PART_VALUE = 2'd2,
    PART_RSVD  = 2'd3
  } part_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_TRUNCATED   = 2'd1,
    ERR_OVERFLOW    = 2'd2,
    ERR_UNSUPPORTED = 2'd3
  } err_e;

  // Status of one continuation byte of a prefix integer.
  typedef struct packed {
    logic done;
    logic overflow;
  } int_status_t;

  // One result of the parser.
  typedef struct packed {
    kind_e            field_kind;
    logic [IdxW-1:0]  table_index;
    part_e            string_part;
    logic             byte_present;
    logic [7:0]       string_byte;
    logic             huffman_coded;
    logic             last_of_part;
    logic             last_of_field;
    err_e             error_code;
  } result_t;

endpackage

// ===== rtl/hfp_int_cont.sv =====
// Continuation step of an HPACK prefix integer: adds seven bits at the
// current shift and checks for overflow. Depends on hfp_pkg.
module hfp_int_cont import hfp_pkg::*; #(
  parameter int unsigned INT_BITS = IntBitsDef,
  parameter int unsigned SHW      = $clog2(INT_BITS + ContBits)
) (
  input  logic [INT_BITS-1:0] acc_i,
  input  logic [SHW-1:0]      shift_i,
  input  logic [7:0]          byte_i,
  output logic [INT_BITS-1:0] acc_o,
  output logic [SHW-1:0]      shift_o,
  output int_status_t         status_o
);

  localparam int unsigned SumW = INT_BITS + ContBits;

  logic [SumW-1:0] addend;
  logic [SumW-1:0] sum;
  logic            shift_full;

  assign shift_full = (shift_i >= SHW'(INT_BITS));
  assign addend     = SumW'(byte_i[6:0]) << shift_i;
  assign sum        = SumW'(acc_i) + addend;
  assign acc_o      = sum[INT_BITS-1:0];

  always_comb begin
    status_o.overflow = shift_full || (sum[SumW-1:INT_BITS] != '0);
    status_o.done     = !byte_i[7];
    shift_o           = byte_i[7] ? (shift_i + SHW'(ContBits)) : shift_i;
  end

endmodule

// ===== rtl/hpack_field_representation_parser.sv =====
// Top level of the HPACK header field representation parser.
// Depends on hfp_pkg and hfp_int_cont.
//
// Flow: a request accepted into the input register is parsed there, and its
// result is loaded from there into the result register.
// Throughput: one request per cycle. A request that gives a result waits in the
// input register, and stalls the input, while an untaken result is held.
// Reset (rst_ni low, asynchronous): both registers empty, parser expects the
// first byte of a header field.
module hpack_field_representation_parser import hfp_pkg::*; #(
  parameter int unsigned INT_BITS = IntBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] block_byte
  input  logic        s_axis_tlast,   // end_of_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] table_index, [24] byte_present, [32:25] string_byte,
  // [33] last_of_part, [35:34] error_code, [39:36] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] field_kind, [3:2] string_part, [4] huffman_coded
  output logic [4:0]  m_axis_tuser,
  output logic        m_axis_tlast    // last_of_field
);

  localparam int unsigned SHW = $clog2(INT_BITS + ContBits);

  // Parse phases, one-hot.
  typedef enum logic [4:0] {
    PH_FIRST     = 5'b00001,
    PH_INDEX     = 5'b00010,
    PH_LEN_FIRST = 5'b00100,
    PH_LEN_CONT  = 5'b01000,
    PH_STRING    = 5'b10000
  } phase_e;

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eob_q;

  // Parser state.
  phase_e              phase_q, phase_d;
  kind_e               kind_q, kind_d;
  logic [INT_BITS-1:0] acc_q, acc_d;
  logic [SHW-1:0]      shift_q, shift_d;
  logic [INT_BITS-1:0] held_q, held_d;
  logic [INT_BITS-1:0] left_q, left_d;
  logic                huff_q, huff_d;
  part_e               part_q, part_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;
  logic    have_res;

  logic s_accept;
  logic advance;
  logic res_load;

  // Continuation step of the integer that is being collected.
  logic [INT_BITS-1:0] cont_acc;
  logic [SHW-1:0]      cont_shift;
  int_status_t         cont_status;

  hfp_int_cont #(
    .INT_BITS (INT_BITS),
    .SHW      (SHW)
  ) u_int_cont (
    .acc_i    (acc_q),
    .shift_i  (shift_q),
    .byte_i   (in_byte_q),
    .acc_o    (cont_acc),
    .shift_o  (cont_shift),
    .status_o (cont_status)
  );

  // One parse step on the byte in the input register. A result is made at
  // most once per byte; kind, index and Huffman flag never change after it
  // within the same step, so they are taken from the next-state values.
  always_comb begin
    logic [7:0]          b;
    logic [7:0]          pref;
    logic [7:0]          v8;
    logic                idx_done;
    logic                len_done;
    logic [INT_BITS-1:0] int_val;
    err_e                err;

    b        = in_byte_q;
    pref     = '0;
    v8       = '0;
    idx_done = 1'b0;
    len_done = 1'b0;
    int_val  = '0;
    err      = ERR_NONE;

    phase_d = phase_q;
    kind_d  = kind_q;
    acc_d   = acc_q;
    shift_d = shift_q;
    held_d  = held_q;
    left_d  = left_q;
    huff_d  = huff_q;
    part_d  = part_q;

    have_res          = 1'b0;
    res               = '0;

    unique case (phase_q)
      PH_FIRST: begin
        part_d  = PART_NONE;
        huff_d  = 1'b0;
        held_d  = '0;
        acc_d   = '0;
        shift_d = '0;
        priority if (b[7]) begin
          kind_d = KIND_INDEXED;
          pref   = PrefIndexed;
        end else if (b[6]) begin
          kind_d = KIND_INCR;
          pref   = PrefIncr;
        end else if (b[5]) begin
          // Dynamic table size update is not supported here.
          kind_d = KIND_INDEXED;
          err    = ERR_UNSUPPORTED;
        end else begin
          kind_d = b[4] ? KIND_NEVER : KIND_NO_INDEX;
          pref   = PrefLiteral;
        end
        if (err == ERR_NONE) begin
          v8 = b & pref;
          if (v8 == pref) begin
            acc_d   = INT_BITS'(v8);
            phase_d = PH_INDEX;
          end else begin
            idx_done = 1'b1;
            int_val  = INT_BITS'(v8);
          end
        end
      end
      PH_INDEX: begin
        if (cont_status.overflow) begin
          err = ERR_OVERFLOW;
        end else begin
          acc_d   = cont_acc;
          shift_d = cont_shift;
          if (cont_status.done) begin
            idx_done = 1'b1;
            int_val  = cont_acc;
          end
        end
      end
      PH_LEN_FIRST: begin
        huff_d  = b[7];
        acc_d   = INT_BITS'(b[6:0]);
        shift_d = '0;
        if (b[6:0] == PrefLength) begin
          phase_d = PH_LEN_CONT;
        end else begin
          len_done = 1'b1;
          int_val  = INT_BITS'(b[6:0]);
        end
      end
      PH_LEN_CONT: begin
        if (cont_status.overflow) begin
          err = ERR_OVERFLOW;
        end else begin
          acc_d   = cont_acc;
          shift_d = cont_shift;
          if (cont_status.done) begin
            len_done = 1'b1;
            int_val  = cont_acc;
          end
        end
      end
      PH_STRING: begin
        left_d               = left_q - INT_BITS'(1);
        have_res             = 1'b1;
        res.string_part      = part_q;
        res.byte_present     = 1'b1;
        res.string_byte      = b;
        if (left_q == INT_BITS'(1)) begin
          res.last_of_part  = 1'b1;
          res.last_of_field = (part_q == PART_VALUE);
          if (part_q == PART_NAME) begin
            part_d  = PART_VALUE;
            phase_d = PH_LEN_FIRST;
          end else begin
            phase_d = PH_FIRST;
          end
        end
      end
      default: begin
        phase_d = PH_FIRST;
      end
    endcase

    // The index is complete: an indexed field ends here, a literal goes on
    // to its name string (new name) or straight to its value string.
    if (idx_done) begin
      if (kind_d == KIND_INDEXED) begin
        if (int_val == '0) begin
          err = ERR_UNSUPPORTED;
        end else begin
          held_d             = int_val;
          have_res           = 1'b1;
          res.string_part    = PART_NONE;
          res.last_of_field  = 1'b1;
          phase_d            = PH_FIRST;
        end
      end else begin
        held_d  = int_val;
        part_d  = (int_val == '0) ? PART_NAME : PART_VALUE;
        phase_d = PH_LEN_FIRST;
      end
    end

    // The string length is complete; an empty string gives one empty result.
    if (len_done) begin
      left_d = int_val;
      if (int_val == '0) begin
        have_res          = 1'b1;
        res.string_part   = part_d;
        res.last_of_part  = 1'b1;
        res.last_of_field = (part_d == PART_VALUE);
        if (part_d == PART_NAME) begin
          part_d  = PART_VALUE;
          phase_d = PH_LEN_FIRST;
        end else begin
          phase_d = PH_FIRST;
        end
      end else begin
        phase_d = PH_STRING;
      end
    end

    // Errors replace any result; a block that ends inside a field marks the
    // result of this byte, or an empty one, as truncated.
    if (err != ERR_NONE) begin
      have_res          = 1'b1;
      res               = '0;
      res.string_part   = part_d;
      res.last_of_field = 1'b1;
      res.error_code    = err;
      phase_d           = PH_FIRST;
    end else if (in_eob_q && (phase_d != PH_FIRST)) begin
      if (!have_res) begin
        res.string_part = part_d;
      end
      have_res          = 1'b1;
      res.last_of_field = 1'b1;
      res.error_code    = ERR_TRUNCATED;
      phase_d           = PH_FIRST;
    end

    res.field_kind    = kind_d;
    res.table_index   = IdxW'(held_d);
    res.huffman_coded = huff_d;
  end

  // Handshakes: a byte that gives no result never waits for the output.
  assign advance       = in_valid_q && (!have_res || !out_valid_q || m_axis_tready);
  assign res_load      = advance && have_res;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_FIRST;
      kind_q      <= KIND_INDEXED;
      acc_q       <= '0;
      shift_q     <= '0;
      held_q      <= '0;
      left_q      <= '0;
      huff_q      <= 1'b0;
      part_q      <= PART_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        acc_q   <= acc_d;
        shift_q <= shift_d;
        held_q  <= held_d;
        left_q  <= left_d;
        huff_q  <= huff_d;
        part_q  <= part_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_eob_q  <= s_axis_tlast;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last_of_field;
  assign m_axis_tuser  = {out_q.huffman_coded, out_q.string_part, out_q.field_kind};
  assign m_axis_tdata  = {4'b0000, out_q.error_code, out_q.last_of_part,
                          out_q.string_byte, out_q.byte_present, out_q.table_index};

  // Every error result closes its field.
  a_err_closes_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && (res.error_code != ERR_NONE) |-> res.last_of_field)
    else $error("error result without last_of_field");

  // After an error result the parser expects a new field.
  a_err_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && (res.error_code != ERR_NONE) |=> (phase_q == PH_FIRST))
    else $error("parser did not restart after an error");

  // A string byte always belongs to a name or value string.
  a_byte_has_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && res.byte_present |->
      (res.string_part == PART_NAME) || (res.string_part == PART_VALUE))
    else $error("string byte outside a string");

  // A string in progress always has bytes left.
  a_string_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STRING) |-> (left_q != '0))
    else $error("string phase with no bytes left");

  // A name string byte never ends the field unless the block was cut short.
  a_name_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && (res.string_part == PART_NAME) && (res.error_code == ERR_NONE)
      |-> !res.last_of_field)
    else $error("name string ended a field");

endmodule

// ===== verif/tb_hpack_field_representation_parser.sv =====
// Self-checking testbench for the HPACK header field representation parser.
// Depends on hfp_pkg and the RTL of hpack_field_representation_parser only.
// Drives header blocks byte by byte and checks every result against its own parser.
`timescale 1ns / 100ps

module tb_hpack_field_representation_parser;
  import hfp_pkg::*;

  // Largest prefix integer the block accepts, and the first-byte patterns.
  localparam logic [63:0] IntLimit      = (64'd1 << IntBitsDef) - 64'd1;
  localparam logic [7:0]  RepIndexed    = 8'h80;
  localparam logic [7:0]  RepIncr       = 8'h40;
  localparam logic [7:0]  RepSizeUpdate = 8'h20;
  localparam logic [7:0]  RepNever      = 8'h10;
  localparam logic [7:0]  RepNoIndex    = 8'h00;
  localparam logic [7:0]  HuffFlag      = 8'h80;
  localparam logic [7:0]  ContFlag      = 8'h80;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    ST_FIELD_START,
    ST_INDEX_CONT,
    ST_LEN_START,
    ST_LEN_CONT,
    ST_STRING
  } parse_st_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  hpack_field_representation_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results the block still owes, oldest first.
  result_t     due_field_results[$];
  // Header block under construction; send_block drains it.
  logic [7:0]  blk[$];
  int unsigned mismatch_count   = 0;
  int unsigned bytes_sent       = 0;
  // Random idling of either side, and a long receiver hold requested by a test.
  bit          tx_idle          = 1'b1;
  bit          rx_idle          = 1'b1;
  int unsigned sink_hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block's parse state and is advanced once
  // per accepted request byte.
  // ---------------------------------------------------------------------------
  parse_st_e   p_state = ST_FIELD_START;
  kind_e       p_kind  = KIND_INDEXED;
  logic [63:0] p_acc   = '0;
  int unsigned p_shift = 0;
  logic [63:0] p_index = '0;
  logic [63:0] p_left  = '0;
  logic        p_huff  = 1'b0;
  part_e       p_part  = PART_NONE;

  // Outcome of the byte being predicted.
  bit          step_has;
  result_t     step_res;
  err_e        step_err;

  function automatic void emit(part_e part, logic present, logic [7:0] sb, logic lp,
                               logic lf);
    step_res.field_kind    = p_kind;
    step_res.table_index   = p_index[IdxW-1:0];
    step_res.string_part   = part;
    step_res.byte_present  = present;
    step_res.string_byte   = sb;
    step_res.huffman_coded = p_huff;
    step_res.last_of_part  = lp;
    step_res.last_of_field = lf;
    step_res.error_code    = ERR_NONE;
    step_has               = 1'b1;
  endfunction

  // One continuation byte of a prefix integer; returns 1 once the integer is
  // complete. Overflow is raised either when the shift has already used up all
  // integer bits or when the new value no longer fits.
  function automatic bit int_cont(logic [7:0] b);
    logic [63:0] v;
    if (p_shift >= IntBitsDef) begin
      step_err = ERR_OVERFLOW;
      return 1'b0;
    end
    v = p_acc + ({57'd0, b[6:0]} << p_shift);
    if (v > IntLimit) begin
      step_err = ERR_OVERFLOW;
      return 1'b0;
    end
    p_acc = v;
    if (b[7]) begin
      p_shift += ContBits;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void index_done(logic [63:0] v);
    if (p_kind == KIND_INDEXED) begin
      // Index zero is not a valid table entry.
      if (v == 0) begin
        step_err = ERR_UNSUPPORTED;
        return;
      end
      p_index = v;
      emit(PART_NONE, 1'b0, 8'h00, 1'b0, 1'b1);
      p_state = ST_FIELD_START;
      return;
    end
    p_index = v;
    p_part  = (v == 0) ? PART_NAME : PART_VALUE;
    p_state = ST_LEN_START;
  endfunction

  function automatic void part_done();
    if (p_part == PART_NAME) begin
      p_part  = PART_VALUE;
      p_state = ST_LEN_START;
    end else begin
      p_state = ST_FIELD_START;
    end
  endfunction

  function automatic void length_done(logic [63:0] v);
    p_left = v;
    if (v == 0) begin
      // An empty string still reports its end.
      emit(p_part, 1'b0, 8'h00, 1'b1, p_part == PART_VALUE);
      part_done();
    end else begin
      p_state = ST_STRING;
    end
  endfunction

  // Advances the predictor by one block byte; step_has/step_res say what the
  // block must produce for it.
  function automatic void parse_block_byte(logic [7:0] b, logic eob);
    logic [7:0] pref;
    pref     = 8'h00;
    step_has = 1'b0;
    step_err = ERR_NONE;
    step_res = '0;
    case (p_state)
      ST_FIELD_START: begin
        p_part  = PART_NONE;
        p_huff  = 1'b0;
        p_index = '0;
        p_acc   = '0;
        p_shift = 0;
        if (b[7]) begin
          p_kind = KIND_INDEXED;
          pref   = PrefIndexed;
        end else if (b[6]) begin
          p_kind = KIND_INCR;
          pref   = PrefIncr;
        end else if (b[5]) begin
          // Dynamic table size updates are not supported.
          p_kind   = KIND_INDEXED;
          step_err = ERR_UNSUPPORTED;
        end else begin
          p_kind = b[4] ? KIND_NEVER : KIND_NO_INDEX;
          pref   = PrefLiteral;
        end
        if (step_err == ERR_NONE) begin
          if ((b & pref) == pref) begin
            p_acc   = {56'd0, pref};
            p_state = ST_INDEX_CONT;
          end else begin
            index_done({56'd0, b & pref});
          end
        end
      end
      ST_INDEX_CONT: begin
        if (int_cont(b)) index_done(p_acc);
      end
      ST_LEN_START: begin
        p_huff  = b[7];
        p_acc   = {57'd0, b[6:0]};
        p_shift = 0;
        if (b[6:0] == PrefLength) p_state = ST_LEN_CONT;
        else length_done({57'd0, b[6:0]});
      end
      ST_LEN_CONT: begin
        if (int_cont(b)) length_done(p_acc);
      end
      ST_STRING: begin
        p_left = p_left - 1;
        if (p_left == 0) begin
          emit(p_part, 1'b1, b, 1'b1, p_part == PART_VALUE);
          part_done();
        end else begin
          emit(p_part, 1'b1, b, 1'b0, 1'b0);
        end
      end
      default: p_state = ST_FIELD_START;
    endcase

    if (step_err != ERR_NONE) begin
      emit(p_part, 1'b0, 8'h00, 1'b0, 1'b1);
      step_res.error_code = step_err;
      p_state             = ST_FIELD_START;
    end else if (eob && p_state != ST_FIELD_START) begin
      // The block ended inside a field: flag whatever this byte gave, or an
      // empty result if it gave nothing.
      if (!step_has) emit(p_part, 1'b0, 8'h00, 1'b0, 1'b1);
      step_res.last_of_field = 1'b1;
      step_res.error_code    = ERR_TRUNCATED;
      p_state                = ST_FIELD_START;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Block builders: HPACK prefix integers, strings and whole fields.
  // ---------------------------------------------------------------------------
  function automatic void put_int(int unsigned nbits, logic [7:0] flags, logic [63:0] v);
    logic [63:0] lim;
    lim = (64'd1 << nbits) - 64'd1;
    if (v < lim) begin
      blk.push_back(flags | v[7:0]);
      return;
    end
    blk.push_back(flags | lim[7:0]);
    v = v - lim;
    while (v >= 128) begin
      blk.push_back({1'b1, v[6:0]});
      v = v >> ContBits;
    end
    blk.push_back({1'b0, v[6:0]});
  endfunction

  function automatic void put_string(logic huff, int unsigned len);
    put_int(7, huff ? HuffFlag : 8'h00, len);
    repeat (len) blk.push_back(8'($urandom));
  endfunction

  function automatic void put_field(kind_e k, logic [63:0] idx, int unsigned name_len,
                                    int unsigned value_len, logic name_huff,
                                    logic value_huff);
    case (k)
      KIND_INDEXED: begin
        put_int(7, RepIndexed, idx);
        return;
      end
      KIND_INCR:     put_int(6, RepIncr, idx);
      KIND_NO_INDEX: put_int(4, RepNoIndex, idx);
      default:       put_int(4, RepNever, idx);
    endcase
    if (idx == 0) put_string(name_huff, name_len);
    put_string(value_huff, value_len);
  endfunction

  // Mostly short strings; now and then one long enough to need a length
  // continuation byte.
  function automatic int unsigned rand_len();
    if ($urandom_range(0, 49) == 0) return $urandom_range(127, 140);
    return $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Each byte waits a random gap (when idling is on) and is then
  // held until the block takes it. tvalid is lowered only when a gap follows,
  // so a back-to-back byte never sees tvalid dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic eob);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_block_byte(b, eob);
    if (step_has) due_field_results.push_back(step_res);
    bytes_sent++;
  endtask

  // Sends the block under construction, marking its last byte as end of block.
  task automatic send_block();
    for (int i = 0; i < blk.size(); i++) send_byte(blk[i], i == blk.size() - 1);
    blk.delete();
  endtask

  // Sender pauses until the block has delivered everything it owes.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_field_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Between results the receiver stalls a random number of
  // cycles; a test may ask for one long hold, counted here.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 6) : 0;
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && sink_hold_cycles == 0);
    end
  end

  function automatic string describe_result(result_t r);
    return $sformatf("kind=%0d index=%0d part=%0d present=%0b byte=%02h huff=%0b lp=%0b lf=%0b err=%0d",
                     r.field_kind, r.table_index, r.string_part, r.byte_present,
                     r.string_byte, r.huffman_coded, r.last_of_part, r.last_of_field,
                     r.error_code);
  endfunction

  function automatic void note_failure(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected: %s", describe_result(want));
      $display("  actual:   %s", describe_result(got));
    end
  endfunction

  // Every accepted result is unpacked and compared with the oldest one due.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.field_kind    = kind_e'(m_axis_tuser[1:0]);
      got.table_index   = m_axis_tdata[23:0];
      got.string_part   = part_e'(m_axis_tuser[3:2]);
      got.byte_present  = m_axis_tdata[24];
      got.string_byte   = m_axis_tdata[32:25];
      got.huffman_coded = m_axis_tuser[4];
      got.last_of_part  = m_axis_tdata[33];
      got.last_of_field = m_axis_tlast;
      got.error_code    = err_e'(m_axis_tdata[35:34]);
      if (due_field_results.size() == 0) begin
        note_failure("result with nothing due", '0, got);
      end else begin
        want = due_field_results.pop_front();
        if (got !== want || m_axis_tdata[39:36] !== 4'h0) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Smallest and largest indexed fields, then an indexed field with index zero.
  task automatic test_indexed_fields();
    put_field(KIND_INDEXED, 1, 0, 0, 1'b0, 1'b0);
    put_field(KIND_INDEXED, IntLimit, 0, 0, 1'b0, 1'b0);
    blk.push_back(RepIndexed);
    send_block();
  endtask

  // A dynamic table size update is rejected as unsupported.
  task automatic test_size_update();
    blk.push_back(RepSizeUpdate | 8'h1F);
    send_block();
  endtask

  // An index whose value exceeds the integer width, then a never-indexed
  // field whose continuation bytes run the shift past the integer width.
  task automatic test_integer_overflow();
    blk.push_back(RepIndexed | PrefIndexed);
    repeat (3) blk.push_back(ContFlag);
    blk.push_back(8'h08);
    blk.push_back(RepNever | PrefLiteral);
    repeat (4) blk.push_back(ContFlag);
    blk.push_back(8'h00);
    send_block();
  endtask

  // New-name literal with a Huffman name and an empty value, then a literal
  // with an indexed name and a one-byte plain value.
  task automatic test_literal_fields();
    put_field(KIND_INCR, 0, 2, 0, 1'b1, 1'b0);
    put_field(KIND_NO_INDEX, 5, 0, 1, 1'b0, 1'b0);
    send_block();
  endtask

  // Name length with a continuation byte, and the block ends mid-string.
  task automatic test_truncated_string();
    blk.push_back(RepIncr);
    put_int(7, HuffFlag, 200);
    repeat (2) blk.push_back(8'($urandom));
    send_block();
  endtask

  // The receiver holds off for a long time while a long field streams in, so
  // the block fills and stalls its input; then the sender waits for drain.
  task automatic test_output_backpressure();
    tx_idle          = 1'b0;
    sink_hold_cycles = 200;
    put_field(KIND_NO_INDEX, 0, 8, 24, 1'b0, 1'b1);
    send_block();
    wait_drained();
    tx_idle = 1'b1;
  endtask

  // Random blocks: mostly well-formed fields with random content, some raw
  // noise bytes and some blocks cut short. Idling is switched on and off in
  // stretches so that both back-to-back and gappy traffic occur.
  task automatic test_random_blocks();
    int unsigned stop_at;
    int unsigned blocks;
    int unsigned keep;
    int unsigned sel;
    kind_e       k;
    logic [63:0] idx;
    stop_at = bytes_sent + 400;
    blocks  = 0;
    while (bytes_sent < stop_at) begin
      if (blocks % 8 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      blocks++;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 99) < 88) begin
          k   = kind_e'($urandom_range(0, 3));
          sel = $urandom_range(0, 9);
          if (sel < 5)      idx = $urandom_range(0, 14);
          else if (sel < 8) idx = $urandom_range(15, 400);
          else              idx = $urandom_range(0, 32'(IntLimit));
          if (k == KIND_INDEXED && idx == 0) idx = 1;
          if (k != KIND_INDEXED && $urandom_range(0, 2) == 0) idx = 0;
          put_field(k, idx, rand_len(), rand_len(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 3)) blk.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        keep = $urandom_range(1, blk.size());
        while (blk.size() > keep) void'(blk.pop_back());
      end
      send_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned drain;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_indexed_fields();
    test_size_update();
    test_integer_overflow();
    test_literal_fields();
    test_truncated_string();
    test_output_backpressure();
    test_random_blocks();

    // Wait for everything due, then give anything stray time to arrive.
    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (due_field_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (due_field_results.size() != 0) begin
      $display("%0d expected results never arrived", due_field_results.size());
      mismatch_count += due_field_results.size();
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : run_limit
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
